>>> hw/rtl/tgco_pkg.sv
package tgco_pkg;

   // fixed field widths
   localparam int SCREEN_W   = 10;
   localparam int INV_W      = 14;
   localparam int EDGE_THR_W = 15;
   localparam int CURSOR_W   = 16;
   localparam int TRI_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // parameter defaults
   localparam int CELL_WIDTH_DEF  = 2;
   localparam int CELL_HEIGHT_DEF = 4;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int SCREEN_BITS_DEF = 10;

   // register reset values
   localparam logic [INV_W-1:0]      INV_SIZE_RST     = INV_W'(4681);
   localparam logic [INV_W-1:0]      INV_HEIGHT_RST   = INV_W'(5405);
   localparam logic [EDGE_THR_W-1:0] BORDER_WIDTH_RST = EDGE_THR_W'(6554);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_COL   = 3'd0,
      CSR_ORIGIN_ROW   = 3'd1,
      CSR_INV_SIZE     = 3'd2,
      CSR_INV_HEIGHT   = 3'd3,
      CSR_BORDER_WIDTH = 3'd4,
      CSR_CURSOR_COL   = 3'd5,
      CSR_CURSOR_ROW   = 3'd6,
      CSR_CURSOR_HALF  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      GLYPH_BLANK      = 2'd0,
      GLYPH_SLASH      = 2'd1,
      GLYPH_BACKSLASH  = 2'd2,
      GLYPH_UNDERSCORE = 2'd3
   } glyph_type;

   typedef struct packed {
      logic [SCREEN_W-1:0]        origin_col;
      logic [SCREEN_W-1:0]        origin_row;
      logic [INV_W-1:0]           inv_size;
      logic [INV_W-1:0]           inv_height;
      logic [EDGE_THR_W-1:0]      border_width;
      logic signed [CURSOR_W-1:0] cursor_col;
      logic signed [CURSOR_W-1:0] cursor_row;
      logic                       cursor_half;
   } cfg_type;

   // grid position of one request, handed from mapping to edge selection
   typedef struct packed {
      logic                    valid;
      logic [TRI_W-1:0]        tri_col;
      logic [TRI_W-1:0]        tri_row;
      logic                    tri_half;
      logic                    on_cursor;
   } pos_type;

endpackage

>>> hw/rtl/tgco_csr.sv
module tgco_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tgco_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgco_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output tgco_pkg::cfg_type                cfg
);
   import tgco_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_COL:   cfg_in.origin_col   = csr_wr_data[SCREEN_W-1:0];
            CSR_ORIGIN_ROW:   cfg_in.origin_row   = csr_wr_data[SCREEN_W-1:0];
            CSR_INV_SIZE:     cfg_in.inv_size     = csr_wr_data[INV_W-1:0];
            CSR_INV_HEIGHT:   cfg_in.inv_height   = csr_wr_data[INV_W-1:0];
            CSR_BORDER_WIDTH: cfg_in.border_width = csr_wr_data[EDGE_THR_W-1:0];
            CSR_CURSOR_COL:   cfg_in.cursor_col   = $signed(csr_wr_data[CURSOR_W-1:0]);
            CSR_CURSOR_ROW:   cfg_in.cursor_row   = $signed(csr_wr_data[CURSOR_W-1:0]);
            CSR_CURSOR_HALF:  cfg_in.cursor_half  = csr_wr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_col   <= '0;
         cfg_ff.origin_row   <= '0;
         cfg_ff.inv_size     <= INV_SIZE_RST;
         cfg_ff.inv_height   <= INV_HEIGHT_RST;
         cfg_ff.border_width <= BORDER_WIDTH_RST;
         cfg_ff.cursor_col   <= '0;
         cfg_ff.cursor_row   <= '0;
         cfg_ff.cursor_half  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/tgco_map.sv
module tgco_map #(
   parameter int CELL_WIDTH  = tgco_pkg::CELL_WIDTH_DEF,
   parameter int CELL_HEIGHT = tgco_pkg::CELL_HEIGHT_DEF,
   parameter int FRAC_BITS   = tgco_pkg::FRAC_BITS_DEF,
   parameter int SCREEN_BITS = tgco_pkg::SCREEN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic [tgco_pkg::SCREEN_W-1:0]  cell_col,
   input  logic [tgco_pkg::SCREEN_W-1:0]  cell_row,
   input  tgco_pkg::cfg_type              cfg,
   output tgco_pkg::pos_type              pos,
   output logic [FRAC_BITS-1:0]           frac_a,
   output logic [FRAC_BITS-1:0]           frac_b
);
   import tgco_pkg::*;

   localparam int SW   = SCREEN_BITS + 1;
   localparam int PXW  = SW + $clog2(CELL_WIDTH + 1);
   localparam int PYW  = SW + $clog2(CELL_HEIGHT + 1);
   localparam int PAW  = PXW + INV_W + 1;
   localparam int PBW  = PYW + INV_W + 1;
   localparam int AW   = ((PAW > PBW) ? PAW : PBW) + 1;
   localparam int CIW  = AW - FRAC_BITS;
   localparam int RIW  = PBW - FRAC_BITS;
   localparam int CMW0 = (CIW > RIW) ? CIW : RIW;
   localparam int CMPW = (CMW0 > CURSOR_W) ? CMW0 : CURSOR_W;

   // stage 0: offset and scale to sub-pixels
   logic [SCREEN_BITS-1:0] col_cut, row_cut, org_col_cut, org_row_cut;
   logic signed [SW-1:0]   dx, dy;
   logic signed [PXW-1:0]  px_ff, px_in;
   logic signed [PYW-1:0]  py_ff, py_in;
   logic                   v0_ff;

   assign col_cut     = SCREEN_BITS'(cell_col);
   assign row_cut     = SCREEN_BITS'(cell_row);
   assign org_col_cut = SCREEN_BITS'(cfg.origin_col);
   assign org_row_cut = SCREEN_BITS'(cfg.origin_row);
   assign dx    = $signed({1'b0, col_cut}) - $signed({1'b0, org_col_cut});
   assign dy    = $signed({1'b0, row_cut}) - $signed({1'b0, org_row_cut});
   assign px_in = PXW'(dx) * $signed(PXW'(CELL_WIDTH));
   assign py_in = PYW'(dy) * $signed(PYW'(CELL_HEIGHT));

   // stage 1: scale by the reciprocals
   logic signed [PAW-1:0] pa_ff, pa_in;
   logic signed [PBW-1:0] b_ff, b_in;
   logic                  v1_ff;

   assign pa_in = PAW'(px_ff) * $signed({1'b0, cfg.inv_size});
   assign b_in  = PBW'(py_ff) * $signed({1'b0, cfg.inv_height});

   // stage 2: slant, split integer and fraction, cursor match
   logic signed [AW-1:0]   a;
   logic signed [CIW-1:0]  c;
   logic signed [RIW-1:0]  r;
   logic [FRAC_BITS:0]     frac_sum;
   logic                   up;
   pos_type                pos_ff, pos_in;
   logic [FRAC_BITS-1:0]   fa_ff, fb_ff;

   assign a        = AW'(pa_ff) - AW'(b_ff >>> 1);
   assign c        = a[AW-1:FRAC_BITS];
   assign r        = b_ff[PBW-1:FRAC_BITS];
   assign frac_sum = {1'b0, a[FRAC_BITS-1:0]} + {1'b0, b_ff[FRAC_BITS-1:0]};
   assign up       = frac_sum[FRAC_BITS];

   always_comb begin
      pos_in.valid     = v1_ff;
      pos_in.tri_col   = TRI_W'(c);
      pos_in.tri_row   = TRI_W'(r);
      pos_in.tri_half  = up;
      pos_in.on_cursor = (CMPW'(c) == CMPW'(cfg.cursor_col)) &&
                         (CMPW'(r) == CMPW'(cfg.cursor_row)) &&
                         (up == cfg.cursor_half);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         pos_ff.valid <= 1'b0;
      end else begin
         v0_ff        <= take;
         v1_ff        <= v0_ff;
         pos_ff.valid <= pos_in.valid;
      end
      px_ff              <= px_in;
      py_ff              <= py_in;
      pa_ff              <= pa_in;
      b_ff               <= b_in;
      pos_ff.tri_col     <= pos_in.tri_col;
      pos_ff.tri_row     <= pos_in.tri_row;
      pos_ff.tri_half    <= pos_in.tri_half;
      pos_ff.on_cursor   <= pos_in.on_cursor;
      fa_ff              <= a[FRAC_BITS-1:0];
      fb_ff              <= b_ff[FRAC_BITS-1:0];
   end

   assign pos    = pos_ff;
   assign frac_a = fa_ff;
   assign frac_b = fb_ff;

endmodule

>>> hw/rtl/tgco_edge.sv
module tgco_edge #(
   parameter int FRAC_BITS = tgco_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tgco_pkg::pos_type                pos,
   input  logic [FRAC_BITS-1:0]             frac_a,
   input  logic [FRAC_BITS-1:0]             frac_b,
   input  logic [tgco_pkg::EDGE_THR_W-1:0]  border_width,
   output logic                             rsp_valid,
   output logic [tgco_pkg::TRI_W-1:0]       rsp_tri_col,
   output logic [tgco_pkg::TRI_W-1:0]       rsp_tri_row,
   output logic                             rsp_tri_half,
   output logic [1:0]                       rsp_glyph,
   output logic                             rsp_on_cursor
);
   import tgco_pkg::*;

   localparam int DW = FRAC_BITS + 1;
   localparam int TW = (DW > EDGE_THR_W) ? DW : EDGE_THR_W;
   localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   logic [DW-1:0] fa, fb, sum, l1, l2, l3, m1, m;
   glyph_type     g1, g2, g3, gm1, gm, glyph_in, glyph_ff;
   pos_type       pos_ff;

   assign fa  = DW'(frac_a);
   assign fb  = DW'(frac_b);
   assign sum = fa + fb;

   always_comb begin
      if (!pos.tri_half) begin
         l1 = ONE - sum;  g1 = GLYPH_SLASH;
         l2 = fa;         g2 = GLYPH_BACKSLASH;
         l3 = fb;         g3 = GLYPH_UNDERSCORE;
      end else begin
         l1 = ONE - fb;   g1 = GLYPH_UNDERSCORE;
         l2 = sum - ONE;  g2 = GLYPH_SLASH;
         l3 = ONE - fa;   g3 = GLYPH_BACKSLASH;
      end
      // strict compares keep the earlier edge on ties
      m1  = (l2 < l1) ? l2 : l1;
      gm1 = (l2 < l1) ? g2 : g1;
      m   = (l3 < m1) ? l3 : m1;
      gm  = (l3 < m1) ? g3 : gm1;
      glyph_in = (TW'(m) >= TW'(border_width)) ? GLYPH_BLANK : gm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff.valid <= 1'b0;
      end else begin
         pos_ff.valid <= pos.valid;
      end
      pos_ff.tri_col   <= pos.tri_col;
      pos_ff.tri_row   <= pos.tri_row;
      pos_ff.tri_half  <= pos.tri_half;
      pos_ff.on_cursor <= pos.on_cursor;
      glyph_ff         <= glyph_in;
   end

   assign rsp_valid     = pos_ff.valid;
   assign rsp_tri_col   = pos_ff.tri_col;
   assign rsp_tri_row   = pos_ff.tri_row;
   assign rsp_tri_half  = pos_ff.tri_half;
   assign rsp_on_cursor = pos_ff.on_cursor;
   assign rsp_glyph     = glyph_ff;

endmodule

>>> hw/rtl/triangle_grid_cell_outliner_top.sv
// Channel   Handshake              Payload
// request   start, busy            req_cell_col, req_cell_row
// result    rsp_valid (strobe)     rsp_tri_col, rsp_tri_row, rsp_tri_half, rsp_glyph,
//                                  rsp_on_cursor
// csr       csr_wr_en              csr_index, csr_wr_data
//
// One request per clock; busy stays low. Each result is strobed after the four
// register stages: scale, reciprocal multiply, slant/split, edge select.
// Synchronous reset clears the pipeline valids and loads the register defaults.
// Results are shown for one cycle; the receiver cannot stall.
module triangle_grid_cell_outliner_top #(
   parameter int CELL_WIDTH  = tgco_pkg::CELL_WIDTH_DEF,
   parameter int CELL_HEIGHT = tgco_pkg::CELL_HEIGHT_DEF,
   parameter int FRAC_BITS   = tgco_pkg::FRAC_BITS_DEF,
   parameter int SCREEN_BITS = tgco_pkg::SCREEN_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tgco_pkg::SCREEN_W-1:0]    req_cell_col,
   input  logic [tgco_pkg::SCREEN_W-1:0]    req_cell_row,
   output logic                             rsp_valid,
   output logic [tgco_pkg::TRI_W-1:0]       rsp_tri_col,
   output logic [tgco_pkg::TRI_W-1:0]       rsp_tri_row,
   output logic                             rsp_tri_half,
   output logic [1:0]                       rsp_glyph,
   output logic                             rsp_on_cursor,
   input  logic                             csr_wr_en,
   input  logic [tgco_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgco_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import tgco_pkg::*;

   cfg_type              cfg;
   pos_type              pos;
   logic [FRAC_BITS-1:0] frac_a, frac_b;
   logic                 take;

   assign busy = 1'b0;
   assign take = start && !busy;

   tgco_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tgco_map #(
      .CELL_WIDTH  (CELL_WIDTH),
      .CELL_HEIGHT (CELL_HEIGHT),
      .FRAC_BITS   (FRAC_BITS),
      .SCREEN_BITS (SCREEN_BITS)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .cell_col (req_cell_col),
      .cell_row (req_cell_row),
      .cfg      (cfg),
      .pos      (pos),
      .frac_a   (frac_a),
      .frac_b   (frac_b)
   );

   tgco_edge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_edge (
      .clock         (clock),
      .reset         (reset),
      .pos           (pos),
      .frac_a        (frac_a),
      .frac_b        (frac_b),
      .border_width  (cfg.border_width),
      .rsp_valid     (rsp_valid),
      .rsp_tri_col   (rsp_tri_col),
      .rsp_tri_row   (rsp_tri_row),
      .rsp_tri_half  (rsp_tri_half),
      .rsp_glyph     (rsp_glyph),
      .rsp_on_cursor (rsp_on_cursor)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |=> ##3 rsp_valid)
      else $error("request did not produce a result after four cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, 4))
      else $error("result without a matching request");

   a_cursor_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_cursor |->
         rsp_tri_half == cfg.cursor_half &&
         rsp_tri_col == cfg.cursor_col[TRI_W-1:0] &&
         rsp_tri_row == cfg.cursor_row[TRI_W-1:0])
      else $error("cursor flag set for a different triangle");

endmodule

>>> tb/cell_outline_checker.sv
module cell_outline_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [tgco_pkg::SCREEN_W-1:0]    req_cell_col,
   input  logic [tgco_pkg::SCREEN_W-1:0]    req_cell_row,
   input  logic                             rsp_valid,
   input  logic [tgco_pkg::TRI_W-1:0]       rsp_tri_col,
   input  logic [tgco_pkg::TRI_W-1:0]       rsp_tri_row,
   input  logic                             rsp_tri_half,
   input  logic [1:0]                       rsp_glyph,
   input  logic                             rsp_on_cursor,
   input  logic                             csr_wr_en,
   input  logic [tgco_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgco_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                               mismatch_count,
   output int                               outstanding
);
   import tgco_pkg::*;

   localparam longint ONE_Q = longint'(1) <<< FRAC_BITS_DEF;

   typedef struct {
      logic [SCREEN_W-1:0] cell_col;
      logic [SCREEN_W-1:0] cell_row;
      logic [TRI_W-1:0]    tri_col;
      logic [TRI_W-1:0]    tri_row;
      logic                tri_half;
      glyph_type           glyph;
      logic                on_cursor;
   } cell_outline_type;

   // shadow copy of the register file
   logic [SCREEN_W-1:0]        origin_col;
   logic [SCREEN_W-1:0]        origin_row;
   logic [INV_W-1:0]           inv_size;
   logic [INV_W-1:0]           inv_height;
   logic [EDGE_THR_W-1:0]      border_width;
   logic signed [CURSOR_W-1:0] cursor_col;
   logic signed [CURSOR_W-1:0] cursor_row;
   logic                       cursor_half;

   cell_outline_type expected_cells[$];

   function automatic cell_outline_type classify_cell(input logic [SCREEN_W-1:0] col,
                                                      input logic [SCREEN_W-1:0] row);
      longint           dx, dy, a, b, c, r, fa, fb, l1, l2, l3, dmin;
      logic             up;
      glyph_type        g1, g2, g3, gsel;
      cell_outline_type res;
      dx = longint'(col) - longint'(origin_col);
      dy = longint'(row) - longint'(origin_row);
      b  = dy * CELL_HEIGHT_DEF * longint'(inv_height);
      // arithmetic shifts floor toward minus infinity
      a  = dx * CELL_WIDTH_DEF * longint'(inv_size) - (b >>> 1);
      c  = a >>> FRAC_BITS_DEF;
      r  = b >>> FRAC_BITS_DEF;
      fa = a - (c <<< FRAC_BITS_DEF);
      fb = b - (r <<< FRAC_BITS_DEF);
      up = (fa + fb >= ONE_Q);
      if (!up) begin
         l1 = ONE_Q - fa - fb; g1 = GLYPH_SLASH;
         l2 = fa;              g2 = GLYPH_BACKSLASH;
         l3 = fb;              g3 = GLYPH_UNDERSCORE;
      end else begin
         l1 = ONE_Q - fb;      g1 = GLYPH_UNDERSCORE;
         l2 = fa + fb - ONE_Q; g2 = GLYPH_SLASH;
         l3 = ONE_Q - fa;      g3 = GLYPH_BACKSLASH;
      end
      // strict compares: on a tie the earlier edge stays
      dmin = l1; gsel = g1;
      if (l2 < dmin) begin
         dmin = l2; gsel = g2;
      end
      if (l3 < dmin) begin
         dmin = l3; gsel = g3;
      end
      if (dmin >= longint'(border_width))
         gsel = GLYPH_BLANK;
      res.cell_col  = col;
      res.cell_row  = row;
      res.tri_col   = c[TRI_W-1:0];
      res.tri_row   = r[TRI_W-1:0];
      res.tri_half  = up;
      res.glyph     = gsel;
      res.on_cursor = (c == longint'(cursor_col)) && (r == longint'(cursor_row)) &&
                      (up == cursor_half);
      return res;
   endfunction

   always @(posedge clock) begin
      cell_outline_type want;
      if (reset) begin
         origin_col   <= '0;
         origin_row   <= '0;
         inv_size     <= INV_SIZE_RST;
         inv_height   <= INV_HEIGHT_RST;
         border_width <= BORDER_WIDTH_RST;
         cursor_col   <= '0;
         cursor_row   <= '0;
         cursor_half  <= 1'b0;
         expected_cells.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_cells.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: col %0d row %0d half %0d glyph %0d cur %0d",
                           $signed(rsp_tri_col), $signed(rsp_tri_row), rsp_tri_half,
                           rsp_glyph, rsp_on_cursor);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tri_col !== want.tri_col || rsp_tri_row !== want.tri_row ||
                   rsp_tri_half !== want.tri_half || rsp_glyph !== want.glyph ||
                   rsp_on_cursor !== want.on_cursor) begin
                  if (mismatch_count < 10)
                     $display({"mismatch cell (%0d,%0d): expected col %0d row %0d half %0d",
                               " glyph %0d cur %0d, got col %0d row %0d half %0d",
                               " glyph %0d cur %0d"},
                              want.cell_col, want.cell_row,
                              $signed(want.tri_col), $signed(want.tri_row), want.tri_half,
                              want.glyph, want.on_cursor,
                              $signed(rsp_tri_col), $signed(rsp_tri_row), rsp_tri_half,
                              rsp_glyph, rsp_on_cursor);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         // predict with the settings in force before any write at this edge
         if (start && !busy)
            expected_cells.push_back(classify_cell(req_cell_col, req_cell_row));
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_COL:   origin_col   <= csr_wr_data[SCREEN_W-1:0];
               CSR_ORIGIN_ROW:   origin_row   <= csr_wr_data[SCREEN_W-1:0];
               CSR_INV_SIZE:     inv_size     <= csr_wr_data[INV_W-1:0];
               CSR_INV_HEIGHT:   inv_height   <= csr_wr_data[INV_W-1:0];
               CSR_BORDER_WIDTH: border_width <= csr_wr_data[EDGE_THR_W-1:0];
               CSR_CURSOR_COL:   cursor_col   <= csr_wr_data;
               CSR_CURSOR_ROW:   cursor_row   <= csr_wr_data;
               CSR_CURSOR_HALF:  cursor_half  <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
      outstanding = expected_cells.size();
   end

endmodule

>>> tb/triangle_grid_cell_outliner_top_tb.sv
module triangle_grid_cell_outliner_top_tb;
   import tgco_pkg::*;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic                  busy;
   logic [SCREEN_W-1:0]   req_cell_col = '0;
   logic [SCREEN_W-1:0]   req_cell_row = '0;
   logic                  rsp_valid;
   logic [TRI_W-1:0]      rsp_tri_col;
   logic [TRI_W-1:0]      rsp_tri_row;
   logic                  rsp_tri_half;
   logic [1:0]            rsp_glyph;
   logic                  rsp_on_cursor;
   logic                  csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data  = '0;
   int                    mismatch_count;
   int                    outstanding;

   // origin currently loaded, used to aim requests near the grid origin
   logic [SCREEN_W-1:0]   aim_col = '0;
   logic [SCREEN_W-1:0]   aim_row = '0;

   triangle_grid_cell_outliner_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cell_col(req_cell_col), .req_cell_row(req_cell_row),
      .rsp_valid(rsp_valid), .rsp_tri_col(rsp_tri_col), .rsp_tri_row(rsp_tri_row),
      .rsp_tri_half(rsp_tri_half), .rsp_glyph(rsp_glyph), .rsp_on_cursor(rsp_on_cursor),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   cell_outline_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cell_col(req_cell_col), .req_cell_row(req_cell_row),
      .rsp_valid(rsp_valid), .rsp_tri_col(rsp_tri_col), .rsp_tri_row(rsp_tri_row),
      .rsp_tri_half(rsp_tri_half), .rsp_glyph(rsp_glyph), .rsp_on_cursor(rsp_on_cursor),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic load_settings(input int ocol, input int orow, input int isz, input int iht,
                                input int bw, input int ccol, input int crow, input int chalf);
      write_reg(CSR_ORIGIN_COL, 16'(ocol));
      write_reg(CSR_ORIGIN_ROW, 16'(orow));
      write_reg(CSR_INV_SIZE, 16'(isz));
      write_reg(CSR_INV_HEIGHT, 16'(iht));
      write_reg(CSR_BORDER_WIDTH, 16'(bw));
      write_reg(CSR_CURSOR_COL, 16'(ccol));
      write_reg(CSR_CURSOR_ROW, 16'(crow));
      write_reg(CSR_CURSOR_HALF, 16'(chalf));
      csr_wr_en <= 1'b0;
      aim_col   = 10'(ocol);
      aim_row   = 10'(orow);
      @(posedge clock);
   endtask

   task automatic send_cell(input logic [SCREEN_W-1:0] col, input logic [SCREEN_W-1:0] row);
      req_cell_col <= col;
      req_cell_row <= row;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // hold off all requests until every result is back and the pipe is empty
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic pick_settings(input int kind);
      int ccol, crow;
      if (kind == 0) begin
         load_settings(0, 0, 1638, 1892, 1966, -32768, -32768, 0);
      end else if (kind == 1) begin
         load_settings(1023, 1023, 10923, 12612, 22938, 32767, 32767, 1);
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            ccol = $urandom_range(0, 65535);
            crow = $urandom_range(0, 65535);
         end else begin
            ccol = int'($urandom_range(0, 6)) - 3;
            crow = int'($urandom_range(0, 6)) - 3;
         end
         load_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(1638, 10923), $urandom_range(1892, 12612),
                       $urandom_range(1966, 22938), ccol, crow, $urandom_range(0, 1));
      end
   endtask

   initial begin
      int phase, n, gap;
      logic [SCREEN_W-1:0] col, row;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: origin corner, ties at the origin, screen corners
      send_cell(10'd0, 10'd0);
      send_cell(10'd1023, 10'd1023);
      send_cell(10'd0, 10'd1023);
      send_cell(10'd1023, 10'd0);
      send_cell(10'd1, 10'd0);
      send_cell(10'd0, 10'd1);
      send_cell(10'd3, 10'd2);
      send_cell(10'd512, 10'd512);
      drain();

      // centered origin: negative offsets, odd b halving, cursor on an up triangle
      load_settings(512, 512, 4681, 5405, 22938, -1, -1, 1);
      send_cell(10'd511, 10'd511);
      send_cell(10'd510, 10'd510);
      send_cell(10'd511, 10'd512);
      send_cell(10'd512, 10'd511);
      send_cell(10'd513, 10'd512);
      send_cell(10'd512, 10'd512);
      send_cell(10'd0, 10'd0);
      send_cell(10'd1023, 10'd1023);
      send_cell(10'd0, 10'd1023);
      send_cell(10'd1023, 10'd0);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         pick_settings(phase);
         for (n = 0; n < 240; n++) begin
            if (phase < 7 && $urandom_range(0, 5) == 0) begin
               gap = $urandom_range(1, 14);
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            if ($urandom_range(0, 1) == 0) begin
               col = 10'(int'(aim_col) + int'($urandom_range(0, 12)) - 6);
               row = 10'(int'(aim_row) + int'($urandom_range(0, 12)) - 6);
            end else begin
               col = 10'($urandom_range(0, 1023));
               row = 10'($urandom_range(0, 1023));
            end
            send_cell(col, row);
         end
         drain();
      end

      if (mismatch_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
